>>> hdl/tlpte_pkg.sv
// Shared operation, status and entry-format constants for the page table engine.
package tlpte_pkg;
   localparam int ENTRY_W = 32;
   localparam int FRAME_W = 20;
   localparam int PROT_W  = 12;
   localparam int VPAGE_W = 16;
   localparam int COUNT_W = 7;

   localparam logic [1:0] FUNC_ENTER   = 2'd0;
   localparam logic [1:0] FUNC_REMOVE  = 2'd1;
   localparam logic [1:0] FUNC_PROTECT = 2'd2;
   localparam logic [1:0] FUNC_EXTRACT = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_MEM   = 2'd1;
   localparam logic [1:0] ST_MAPPED   = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   localparam logic [PROT_W-1:0] NOCACHE_RESET = 12'd16;

   typedef logic [ENTRY_W-1:0] entry_type;
endpackage

>>> hdl/tlpte_mem.sv
// Single-port synchronous page entry store with registered read data.
module tlpte_mem #(
   parameter int ADDR_W = 16
) (
   input  logic                   clock,
   input  logic [ADDR_W-1:0]      addr,
   input  logic                   we,
   input  tlpte_pkg::entry_type   wdata,
   output tlpte_pkg::entry_type   rdata
);
   import tlpte_pkg::*;

   entry_type mem_ff [2**ADDR_W];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

>>> hdl/two_level_page_table_engine_top.sv
// Top level of the two-level page table engine: sequencer, directory and register.
//
// One operation is taken per start while busy is low. Enter and extract hold busy for
// a memory read and an evaluate/write-back, and give their result in the cycle after.
// An enter that finds no table and has no page to build one, and an extract that finds
// no table, give their result straight from the lookup instead. An enter that creates a
// table first sweeps all 2**TABLE_BITS entries of it to zero through the single memory
// port and then writes the new entry. Remove and protect give each page whose table exists
// a read and an evaluate/write-back, and each page whose table is absent only the lookup.
// Each result appears for one cycle with rsp_valid; the receiver cannot stall, and
// rsp_last marks the final result of an operation. A range of zero pages gives no
// result.
module two_level_page_table_engine_top #(
   parameter int DIR_BITS   = 6,
   parameter int TABLE_BITS = 10,
   parameter int MAX_RANGE  = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_vpage,
   input  logic [19:0] req_frame,
   input  logic [11:0] req_prot,
   input  logic [6:0]  req_page_count,
   input  logic        req_nocache,
   input  logic        req_zero_fill,
   input  logic        req_table_page_available,
   input  logic        csr_we,
   input  logic [11:0] csr_wdata,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [19:0] rsp_frame_out,
   output logic [15:0] rsp_result_vpage,
   output logic        rsp_invalidate,
   output logic        rsp_invalidate_table,
   output logic        rsp_zero_page,
   output logic        rsp_last
);
   import tlpte_pkg::*;

   localparam int SLOT_W = DIR_BITS + TABLE_BITS;
   localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_RANGE);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOOK = 3'd1;
   localparam logic [2:0] S_EVAL = 3'd2;
   localparam logic [2:0] S_CLR  = 3'd3;
   localparam logic [2:0] S_FILL = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [1:0]            func_ff, func_in;
   logic [15:0]           vp_ff, vp_in;
   logic [19:0]           frame_ff, frame_in;
   logic [11:0]           prot_ff, prot_in;
   logic [COUNT_W-1:0]    cnt_ff, cnt_in;
   logic                  zfill_ff, zfill_in;
   logic                  avail_ff, avail_in;
   logic                  newtab_ff, newtab_in;
   logic [TABLE_BITS-1:0] clr_ff, clr_in;
   logic [2**DIR_BITS-1:0] dir_valid_ff, dir_valid_in;
   logic [11:0]           nocache_ff;

   logic        rv_in, rinv_in, rinvt_in, rzp_in, rlast_in;
   logic [1:0]  rst_in;
   logic [19:0] rfr_in;
   logic [15:0] rvp_in;

   logic [DIR_BITS-1:0] dir_idx;
   logic [SLOT_W-1:0]   slot, mem_addr;
   logic                mem_we;
   entry_type           mem_wdata, mem_rdata, new_entry;
   logic [COUNT_W-1:0]  req_cnt;
   logic                is_last;

   assign dir_idx  = DIR_BITS'(32'(vp_ff) >> TABLE_BITS);
   assign slot     = {dir_idx, vp_ff[TABLE_BITS-1:0]};
   assign is_last  = (cnt_ff == COUNT_W'(1));
   assign req_cnt  = (req_page_count > MAX_CNT) ? MAX_CNT : req_page_count;
   // Enter entries carry the option bits already merged into prot_ff.
   assign new_entry = {frame_ff, prot_ff | 12'h001};

   tlpte_mem #(.ADDR_W(SLOT_W)) u_mem (
      .clock (clock),
      .addr  (mem_addr),
      .we    (mem_we),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      vp_in        = vp_ff;
      frame_in     = frame_ff;
      prot_in      = prot_ff;
      cnt_in       = cnt_ff;
      zfill_in     = zfill_ff;
      avail_in     = avail_ff;
      newtab_in    = newtab_ff;
      clr_in       = clr_ff;
      dir_valid_in = dir_valid_ff;
      mem_addr     = slot;
      mem_we       = 1'b0;
      mem_wdata    = '0;
      rv_in    = 1'b0;
      rst_in   = ST_OK;
      rfr_in   = '0;
      rvp_in   = vp_ff;
      rinv_in  = 1'b0;
      rinvt_in = 1'b0;
      rzp_in   = 1'b0;
      rlast_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in   = req_func;
               vp_in     = req_vpage;
               frame_in  = req_frame;
               prot_in   = (req_func == FUNC_ENTER && req_nocache) ?
                           (req_prot | nocache_ff) : req_prot;
               zfill_in  = req_zero_fill;
               avail_in  = req_table_page_available;
               newtab_in = 1'b0;
               if (req_func == FUNC_REMOVE || req_func == FUNC_PROTECT) begin
                  cnt_in = req_cnt;
                  if (req_cnt != '0) begin
                     state_in = S_LOOK;
                  end
               end else begin
                  cnt_in   = COUNT_W'(1);
                  state_in = S_LOOK;
               end
            end
         end
         S_LOOK: begin
            if (dir_valid_ff[dir_idx]) begin
               state_in = S_EVAL;
            end else if (func_ff == FUNC_ENTER) begin
               if (avail_ff) begin
                  dir_valid_in[dir_idx] = 1'b1;
                  newtab_in = 1'b1;
                  clr_in    = '0;
                  state_in  = S_CLR;
               end else begin
                  rv_in    = 1'b1;
                  rst_in   = ST_NO_MEM;
                  rlast_in = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               rv_in    = 1'b1;
               rst_in   = ST_NOTFOUND;
               rlast_in = is_last;
               cnt_in   = cnt_ff - COUNT_W'(1);
               vp_in    = vp_ff + 16'd1;
               state_in = is_last ? S_IDLE : S_LOOK;
            end
         end
         S_EVAL: begin
            rv_in = 1'b1;
            case (func_ff)
               FUNC_ENTER: begin
                  rlast_in = 1'b1;
                  rinvt_in = newtab_ff;
                  state_in = S_IDLE;
                  if (mem_rdata[0]) begin
                     rst_in = ST_MAPPED;
                  end else begin
                     mem_we    = 1'b1;
                     mem_wdata = new_entry;
                     rinv_in   = 1'b1;
                     rzp_in    = zfill_ff;
                  end
               end
               FUNC_EXTRACT: begin
                  rlast_in = 1'b1;
                  state_in = S_IDLE;
                  if (mem_rdata[0]) begin
                     rfr_in = mem_rdata[31:12];
                  end else begin
                     rst_in = ST_NOTFOUND;
                  end
               end
               default: begin
                  rlast_in = is_last;
                  cnt_in   = cnt_ff - COUNT_W'(1);
                  vp_in    = vp_ff + 16'd1;
                  state_in = is_last ? S_IDLE : S_LOOK;
                  if (mem_rdata[0]) begin
                     mem_we    = 1'b1;
                     mem_wdata = (func_ff == FUNC_REMOVE) ? '0 :
                                 {mem_rdata[31:12], prot_ff};
                     rinv_in   = 1'b1;
                  end else begin
                     rst_in = ST_NOTFOUND;
                  end
               end
            endcase
         end
         S_CLR: begin
            // A new table is swept to zero before its first entry is written.
            mem_addr = {dir_idx, clr_ff};
            mem_we   = 1'b1;
            clr_in   = clr_ff + TABLE_BITS'(1);
            if (clr_ff == {TABLE_BITS{1'b1}}) begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            mem_we    = 1'b1;
            mem_wdata = new_entry;
            rv_in     = 1'b1;
            rinv_in   = 1'b1;
            rinvt_in  = 1'b1;
            rzp_in    = zfill_ff;
            rlast_in  = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dir_valid_ff <= '0;
         nocache_ff   <= NOCACHE_RESET;
         rsp_valid    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dir_valid_ff <= dir_valid_in;
         rsp_valid    <= rv_in;
         if (csr_we) begin
            nocache_ff <= csr_wdata;
         end
      end
      func_ff   <= func_in;
      vp_ff     <= vp_in;
      frame_ff  <= frame_in;
      prot_ff   <= prot_in;
      cnt_ff    <= cnt_in;
      zfill_ff  <= zfill_in;
      avail_ff  <= avail_in;
      newtab_ff <= newtab_in;
      clr_ff    <= clr_in;
      rsp_status           <= rst_in;
      rsp_frame_out        <= rfr_in;
      rsp_result_vpage     <= rvp_in;
      rsp_invalidate       <= rinv_in;
      rsp_invalidate_table <= rinvt_in;
      rsp_zero_page        <= rzp_in;
      rsp_last             <= rlast_in;
   end

   assign busy = (state_ff != S_IDLE);

`ifndef SYNTHESIS
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> state_ff == S_IDLE)
      else $error("final transfer while sequencer still active");
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("non-final transfer with sequencer idle");
   a_clr_dir: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLR |-> dir_valid_ff[dir_idx])
      else $error("table sweep without directory bit set");
   a_newtab_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalidate_table |-> rsp_status == ST_OK || rsp_status == ST_MAPPED)
      else $error("table creation flagged on a failed enter");
`endif
endmodule
